FILE: hw/rtl/sliding_window_median_assert.svh
// Assertion macros shared by the sliding window median RTL.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// Checked at every rising edge while out of reset.
`define SWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define SWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hw/rtl/swm_pkg.sv
// Package for the sliding window median: sizes, codes, shared types.
// No dependencies.
package swm_pkg;

  localparam int unsigned NumSlots = 10;
  localparam int unsigned WinLen   = NumSlots - 1;
  localparam int unsigned SampleW  = 24;
  localparam int unsigned CountW   = 4;
  localparam int unsigned IdxW     = $clog2(WinLen);
  localparam int unsigned RankW    = $clog2(WinLen);
  localparam int unsigned ScanW    = $clog2(WinLen);

  localparam logic FuncPush  = 1'b0;
  localparam logic FuncClear = 1'b1;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [RankW-1:0]   rank_t;
  typedef logic [CountW-1:0]  count_t;

  typedef enum logic [1:0] {
    SwmIdle,
    SwmScan,
    SwmResult
  } swm_state_e;

  typedef struct packed {
    logic    vld;
    idx_t    idx;
    sample_t val;
  } swm_probe_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic scan;
  } swm_cell_ctrl_t;

endpackage

FILE: hw/rtl/swm_cell.sv
// One window cell: holds a sample, a circulating probe and the sample's rank.
// Depends on swm_pkg.
module swm_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  swm_pkg::swm_cell_ctrl_t ctrl_i,
  input  swm_pkg::idx_t          cell_idx_i,
  input  logic                   shift_vld_i,
  input  swm_pkg::sample_t       shift_val_i,
  input  swm_pkg::swm_probe_t    probe_i,
  output swm_pkg::swm_probe_t    probe_o,
  output logic                   vld_o,
  output swm_pkg::sample_t       val_o,
  output swm_pkg::rank_t         rank_o
);

  logic                vld_q, vld_d;
  logic                pvld_q, pvld_d;
  swm_pkg::sample_t    val_q, val_d;
  swm_pkg::idx_t       pidx_q, pidx_d;
  swm_pkg::sample_t    pval_q, pval_d;
  swm_pkg::rank_t      rank_q, rank_d;
  logic                hit;

  // Probe ranks below this sample; ties go to the lower cell index.
  assign hit = pvld_q && ((pval_q < val_q) || ((pval_q == val_q) && (pidx_q < cell_idx_i)));

  always_comb begin
    vld_d  = vld_q;
    pvld_d = pvld_q;
    val_d  = val_q;
    pidx_d = pidx_q;
    pval_d = pval_q;
    rank_d = rank_q;
    priority if (ctrl_i.clear) begin
      vld_d  = 1'b0;
      pvld_d = 1'b0;
    end else if (ctrl_i.shift) begin
      vld_d  = shift_vld_i;
      val_d  = shift_val_i;
      pvld_d = shift_vld_i;
      pidx_d = cell_idx_i;
      pval_d = shift_val_i;
      rank_d = '0;
    end else if (ctrl_i.scan) begin
      rank_d = rank_q + swm_pkg::rank_t'(hit);
      pvld_d = probe_i.vld;
      pidx_d = probe_i.idx;
      pval_d = probe_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      pvld_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      pvld_q <= pvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    pidx_q <= pidx_d;
    pval_q <= pval_d;
    rank_q <= rank_d;
  end

  assign probe_o = '{vld: pvld_q, idx: pidx_q, val: pval_q};
  assign vld_o   = vld_q;
  assign val_o   = val_q;
  assign rank_o  = rank_q;

endmodule

FILE: hw/rtl/sliding_window_median.sv
// Sliding window median: a row of nine rank cells plus the sequencer.
// Depends on swm_pkg, swm_cell and sliding_window_median_assert.svh.
//
// Use:
//   Input stream s_axis: tdata carries the 24-bit sample in microseconds,
//   tuser selects push (0) or clear (1). Output stream m_axis: one word per
//   input word with the median and the number of held samples.
//   A push shifts the sample into the cell row (the oldest of nine drops
//   out), then each stored sample circulates once around the row while every
//   cell counts how many samples rank below its own. The result state then
//   picks the cell whose rank is count/2 into the output register.
//   s_axis_tready is high only while the sequencer is idle. The output
//   register holds its word while m_axis_tready is low; a new input word may
//   still be taken, and its result waits until the register frees.
//   Reset empties the window and drops any pending output word.
`include "sliding_window_median_assert.svh"

module sliding_window_median (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] sample_us
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [23:0] median_us, [27:24] held_count, [31:28] zero
);

  localparam int unsigned WinLen = swm_pkg::WinLen;

  swm_pkg::swm_state_e     state_q, state_d;
  swm_pkg::count_t         count_q, count_d;
  logic [swm_pkg::ScanW-1:0] scan_q, scan_d;
  logic                    out_vld_q, out_vld_d;
  swm_pkg::sample_t        out_med_q, out_med_d;
  swm_pkg::count_t         out_cnt_q, out_cnt_d;
  swm_pkg::swm_cell_ctrl_t ctrl;
  logic                    accept;
  logic                    load_out;

  logic [WinLen-1:0]       cell_vld;
  swm_pkg::sample_t        cell_val  [WinLen];
  swm_pkg::rank_t          cell_rank [WinLen];
  swm_pkg::swm_probe_t     cell_probe[WinLen];
  logic [WinLen-1:0]       sel;
  swm_pkg::sample_t        median;
  swm_pkg::rank_t          mid_rank;

  assign s_axis_tready = (state_q == swm_pkg::SwmIdle);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign load_out = (state_q == swm_pkg::SwmResult) && (!out_vld_q || m_axis_tready);

  for (genvar i = 0; i < WinLen; i++) begin : g_cell
    localparam int unsigned Prev = (i == 0) ? WinLen - 1 : i - 1;
    swm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .cell_idx_i  (swm_pkg::idx_t'(i)),
      .shift_vld_i ((i == 0) ? 1'b1 : cell_vld[Prev]),
      .shift_val_i ((i == 0) ? s_axis_tdata : cell_val[Prev]),
      .probe_i     (cell_probe[Prev]),
      .probe_o     (cell_probe[i]),
      .vld_o       (cell_vld[i]),
      .val_o       (cell_val[i]),
      .rank_o      (cell_rank[i])
    );
  end

  assign mid_rank = swm_pkg::rank_t'(count_q >> 1);

  always_comb begin
    median = '0;
    for (int unsigned i = 0; i < WinLen; i++) begin
      sel[i] = cell_vld[i] && (cell_rank[i] == mid_rank);
      median = median | (sel[i] ? cell_val[i] : '0);
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    scan_d    = scan_q;
    out_vld_d = out_vld_q;
    out_med_d = out_med_q;
    out_cnt_d = out_cnt_q;
    ctrl      = '0;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      swm_pkg::SwmIdle: begin
        if (accept) begin
          if (s_axis_tuser == swm_pkg::FuncClear) begin
            ctrl.clear = 1'b1;
            count_d    = '0;
            state_d    = swm_pkg::SwmResult;
          end else begin
            ctrl.shift = 1'b1;
            count_d    = (count_q == swm_pkg::count_t'(WinLen)) ? count_q : count_q + 1'b1;
            scan_d     = '0;
            state_d    = swm_pkg::SwmScan;
          end
        end
      end
      swm_pkg::SwmScan: begin
        ctrl.scan = 1'b1;
        scan_d    = scan_q + 1'b1;
        if (scan_q == swm_pkg::ScanW'(WinLen - 1)) begin
          state_d = swm_pkg::SwmResult;
        end
      end
      swm_pkg::SwmResult: begin
        if (load_out) begin
          out_vld_d = 1'b1;
          out_med_d = median;
          out_cnt_d = count_q;
          state_d   = swm_pkg::SwmIdle;
        end
      end
      default: begin
        state_d = swm_pkg::SwmIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= swm_pkg::SwmIdle;
      count_q   <= '0;
      scan_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      scan_q    <= scan_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_med_q <= out_med_d;
    out_cnt_q <= out_cnt_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_cnt_q, out_med_q};

  `SWM_ASSERT(a_count_max, count_q <= swm_pkg::count_t'(WinLen), "held count above window")
  `SWM_ASSERT(a_count_cells, $countones(cell_vld) == int'(count_q), "count disagrees with cells")
  `SWM_ASSERT(a_one_median, (state_q == swm_pkg::SwmResult && count_q != '0) |-> $onehot(sel), "median rank not unique")
  `SWM_ASSERT(a_out_from_result, $rose(out_vld_q) |-> $past(state_q == swm_pkg::SwmResult), "output loaded outside result")
  `SWM_ASSERT_ALWAYS(a_reset_out, !rst_ni |=> !out_vld_q, "output valid after reset")

endmodule
